// File: hw/rtl/nsfe_pkg.sv
// Shared types, codes and character helpers for the NMEA sentence field extractor.
package nsfe_pkg;

  localparam int unsigned MAX_FIELDS = 31;
  localparam int unsigned FIELD_W    = $clog2(MAX_FIELDS + 1);

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] START_RESET  = 8'h24;
  localparam logic [7:0] END_RESET    = 8'h2A;
  localparam logic [7:0] SEP_RESET    = 8'h2C;

  // configuration register indexes
  localparam logic [1:0] CFG_START_CHAR = 2'd0;
  localparam logic [1:0] CFG_END_MARK   = 2'd1;
  localparam logic [1:0] CFG_SEPARATOR  = 2'd2;

  // message kinds
  localparam logic [2:0] KIND_GGA     = 3'd0;
  localparam logic [2:0] KIND_GLL     = 3'd1;
  localparam logic [2:0] KIND_GSA     = 3'd2;
  localparam logic [2:0] KIND_GSV     = 3'd3;
  localparam logic [2:0] KIND_RMC     = 3'd4;
  localparam logic [2:0] KIND_VTG     = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd6;

  // talker sources
  localparam logic [2:0] TALKER_GP   = 3'd0;
  localparam logic [2:0] TALKER_LL   = 3'd1;
  localparam logic [2:0] TALKER_GL   = 3'd2;
  localparam logic [2:0] TALKER_GB   = 3'd3;
  localparam logic [2:0] TALKER_GN   = 3'd4;
  localparam logic [2:0] TALKER_NONE = 3'd5;

  // fields of interest
  localparam logic [FIELD_W-1:0] FLD_TIME = FIELD_W'(1);
  localparam logic [FIELD_W-1:0] FLD_LAT  = FIELD_W'(4);
  localparam logic [FIELD_W-1:0] FLD_LON  = FIELD_W'(6);
  localparam logic [FIELD_W-1:0] FLD_SATS = FIELD_W'(7);
  localparam logic [FIELD_W-1:0] FLD_DATE = FIELD_W'(9);

  typedef struct packed {
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic [6:0] day;
    logic [6:0] month;
    logic [6:0] year;
    logic [6:0] sats;
    logic [7:0] lat;
    logic [7:0] lon;
  } values_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] kind;
    logic [2:0] talker;
    values_t    vals;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [6:0] digit_pair(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] da;
    logic [7:0] db;
    logic [7:0] sum;
    da  = a - 8'h30;
    db  = b - 8'h30;
    sum = {da[4:0], 3'b000} + {da[6:0], 1'b0} + db;
    if (!is_digit(a)) return 7'd0;
    if (!is_digit(b)) return da[6:0];
    return sum[6:0];
  endfunction

  function automatic logic [2:0] find_kind(input logic [23:0] k);
    unique case (k)
      {8'h47, 8'h47, 8'h41}: return KIND_GGA;
      {8'h47, 8'h4C, 8'h4C}: return KIND_GLL;
      {8'h47, 8'h53, 8'h41}: return KIND_GSA;
      {8'h47, 8'h53, 8'h56}: return KIND_GSV;
      {8'h52, 8'h4D, 8'h43}: return KIND_RMC;
      {8'h56, 8'h54, 8'h47}: return KIND_VTG;
      default:               return KIND_UNKNOWN;
    endcase
  endfunction

  function automatic logic [2:0] find_talker(input logic [15:0] t);
    unique case (t)
      {8'h47, 8'h50}: return TALKER_GP;
      {8'h4C, 8'h4C}: return TALKER_LL;
      {8'h47, 8'h4C}: return TALKER_GL;
      {8'h47, 8'h42}: return TALKER_GB;
      {8'h47, 8'h4E}: return TALKER_GN;
      default:        return TALKER_NONE;
    endcase
  endfunction

endpackage

// File: hw/rtl/nmea_sentence_field_extractor.sv
// NMEA sentence field extractor: per-byte parser, commit logic and result skid buffer.
//
// Usage: bytes of the serial stream enter on the input channel (in_valid_i, in_stall_o,
// rx_byte_i), one per beat. Nothing comes out until a newline closes an open sentence;
// that byte yields exactly one result beat on the output channel (out_valid_o,
// out_stall_i and the field ports), carrying the end-mark flag, message kind, held
// talker and the committed time, date, satellite count and hemisphere characters.
// Throughput: one byte per cycle while in_stall_o is low; all per-byte work is a few
// compares and a multiply-by-ten accumulate between the parser state registers.
// Stalling: a result register and a one-entry skid register sit on the output.
// While the receiver stalls, input keeps being taken until the skid register holds
// a result; in_stall_o then rises until the output drains.
// Reset: parser idle, talker none, committed values zero, start/end-mark/separator
// registers back to dollar, asterisk and comma. The user writes configuration through
// cfg_we_i/cfg_index_i/cfg_data_i only while the block is idle, unenforced by the block.
module nmea_sentence_field_extractor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       sentence_ok_o,
  output logic [2:0] message_kind_o,
  output logic [2:0] talker_code_o,
  output logic [6:0] hour_value_o,
  output logic [6:0] minute_value_o,
  output logic [6:0] second_value_o,
  output logic [6:0] day_value_o,
  output logic [6:0] month_value_o,
  output logic [6:0] year_value_o,
  output logic [6:0] satellite_count_o,
  output logic [7:0] lat_hemisphere_o,
  output logic [7:0] lon_hemisphere_o
);
  import nsfe_pkg::*;

  // configuration
  logic [7:0] start_char_q, end_char_q, sep_char_q;

  // parser state
  logic               in_sentence_q, in_sentence_d;
  logic [FIELD_W-1:0] field_num_q, field_num_d;
  logic [3:0]         field_len_q, field_len_d;
  logic [2:0]         char_pos_q, char_pos_d;
  logic [15:0]        talker_q, talker_d;
  logic [23:0]        kind_chars_q, kind_chars_d;
  logic [7:0]         capture_q [6];
  logic [7:0]         capture_d [6];
  logic               end_seen_q, end_seen_d;
  logic [6:0]         sat_acc_q, sat_acc_d;
  logic               sat_run_q, sat_run_d;

  // pending values and flags
  logic    p_time_q, p_time_d, p_date_q, p_date_d, p_sats_q, p_sats_d;
  logic    p_lat_q, p_lat_d, p_lon_q, p_lon_d;
  values_t pend_q, pend_d;

  // committed state
  logic [2:0] source_q, source_d;
  values_t    comm_q, comm_d;

  // output stage
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res;
  logic    res_valid, accept, out_ready;

  logic [10:0] sat_next;
  logic [3:0]  digit_val;
  logic [2:0]  kind;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_ready  = !out_valid_q || !out_stall_i;

  // low nibble of an ASCII digit is its value
  assign digit_val = rx_byte_i[3:0];
  assign sat_next  = {1'b0, sat_acc_q, 3'b000} + {3'b000, sat_acc_q, 1'b0}
                     + {7'd0, digit_val[3:0]};
  assign kind      = (char_pos_q >= 3'd5) ? find_kind(kind_chars_q) : KIND_UNKNOWN;

  always_comb begin
    in_sentence_d = in_sentence_q;
    field_num_d   = field_num_q;
    field_len_d   = field_len_q;
    char_pos_d    = char_pos_q;
    talker_d      = talker_q;
    kind_chars_d  = kind_chars_q;
    capture_d     = capture_q;
    end_seen_d    = end_seen_q;
    sat_acc_d     = sat_acc_q;
    sat_run_d     = sat_run_q;
    p_time_d      = p_time_q;
    p_date_d      = p_date_q;
    p_sats_d      = p_sats_q;
    p_lat_d       = p_lat_q;
    p_lon_d       = p_lon_q;
    pend_d        = pend_q;
    source_d      = source_q;
    comm_d        = comm_q;
    res_valid     = 1'b0;

    if (accept) begin
      if (!in_sentence_q) begin
        if (rx_byte_i == start_char_q) begin
          in_sentence_d = 1'b1;
          field_num_d   = '0;
          char_pos_d    = '0;
          talker_d      = '0;
          kind_chars_d  = '0;
          end_seen_d    = 1'b0;
          p_time_d      = 1'b0;
          p_date_d      = 1'b0;
          p_sats_d      = 1'b0;
          p_lat_d       = 1'b0;
          p_lon_d       = 1'b0;
          field_len_d   = '0;
          for (int i = 0; i < 6; i++) capture_d[i] = '0;
          sat_acc_d     = '0;
          sat_run_d     = 1'b1;
        end
      end else if (rx_byte_i != NEWLINE_CHAR) begin
        if (rx_byte_i == end_char_q) end_seen_d = 1'b1;
        if (char_pos_q < 3'd2) begin
          if (char_pos_q[0]) talker_d[7:0] = rx_byte_i;
          else               talker_d[15:8] = rx_byte_i;
        end else if (char_pos_q < 3'd5) begin
          unique case (char_pos_q)
            3'd2:    kind_chars_d[23:16] = rx_byte_i;
            3'd3:    kind_chars_d[15:8]  = rx_byte_i;
            default: kind_chars_d[7:0]   = rx_byte_i;
          endcase
        end
        if (char_pos_q < 3'd5) char_pos_d = char_pos_q + 3'd1;

        if (rx_byte_i == sep_char_q) begin
          // close the field using what it collected, then open the next one
          priority if (field_num_q == FLD_TIME && field_len_q >= 4'd6) begin
            pend_d.hour   = digit_pair(capture_q[0], capture_q[1]);
            pend_d.minute = digit_pair(capture_q[2], capture_q[3]);
            pend_d.second = digit_pair(capture_q[4], capture_q[5]);
            p_time_d      = 1'b1;
          end else if (field_num_q == FLD_DATE && field_len_q >= 4'd6) begin
            pend_d.day    = digit_pair(capture_q[0], capture_q[1]);
            pend_d.month  = digit_pair(capture_q[2], capture_q[3]);
            pend_d.year   = digit_pair(capture_q[4], capture_q[5]);
            p_date_d      = 1'b1;
          end else if (field_num_q == FLD_LAT) begin
            pend_d.lat = (field_len_q != 4'd0) ? capture_q[0] : 8'd0;
            p_lat_d    = 1'b1;
          end else if (field_num_q == FLD_LON) begin
            pend_d.lon = (field_len_q != 4'd0) ? capture_q[0] : 8'd0;
            p_lon_d    = 1'b1;
          end else if (field_num_q == FLD_SATS) begin
            pend_d.sats = sat_acc_q;
            p_sats_d    = 1'b1;
          end else begin
          end
          if (field_num_q < FIELD_W'(MAX_FIELDS)) field_num_d = field_num_q + FIELD_W'(1);
          field_len_d = '0;
          for (int i = 0; i < 6; i++) capture_d[i] = '0;
          sat_acc_d   = '0;
          sat_run_d   = 1'b1;
        end else begin
          if (field_len_q < 4'd6) capture_d[field_len_q[2:0]] = rx_byte_i;
          if (field_len_q < 4'd15) field_len_d = field_len_q + 4'd1;
          if (sat_run_q && is_digit(rx_byte_i)) begin
            sat_acc_d = (sat_next > 11'd99) ? 7'd99 : sat_next[6:0];
          end else begin
            sat_run_d = 1'b0;
          end
        end
      end else begin
        // newline closes the sentence; commit only with the end mark
        in_sentence_d = 1'b0;
        res_valid     = 1'b1;
        if (end_seen_q) begin
          if (source_q == TALKER_NONE && char_pos_q >= 3'd2) source_d = find_talker(talker_q);
          if (kind == KIND_GGA) begin
            if (p_time_q) begin
              comm_d.hour   = pend_q.hour;
              comm_d.minute = pend_q.minute;
              comm_d.second = pend_q.second;
            end
            if (p_sats_q) comm_d.sats = pend_q.sats;
          end else if (kind == KIND_RMC) begin
            if (p_time_q) begin
              comm_d.hour   = pend_q.hour;
              comm_d.minute = pend_q.minute;
              comm_d.second = pend_q.second;
            end
            if (p_date_q) begin
              comm_d.day   = pend_q.day;
              comm_d.month = pend_q.month;
              comm_d.year  = pend_q.year;
            end
            if (p_lat_q) comm_d.lat = pend_q.lat;
            if (p_lon_q) comm_d.lon = pend_q.lon;
          end
        end
      end
    end
  end

  always_comb begin
    res.ok     = end_seen_q;
    res.kind   = kind;
    res.talker = source_d;
    res.vals   = comm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q  <= START_RESET;
      end_char_q    <= END_RESET;
      sep_char_q    <= SEP_RESET;
      in_sentence_q <= 1'b0;
      field_num_q   <= '0;
      field_len_q   <= '0;
      char_pos_q    <= '0;
      talker_q      <= '0;
      kind_chars_q  <= '0;
      for (int i = 0; i < 6; i++) capture_q[i] <= '0;
      end_seen_q    <= 1'b0;
      sat_acc_q     <= '0;
      sat_run_q     <= 1'b1;
      p_time_q      <= 1'b0;
      p_date_q      <= 1'b0;
      p_sats_q      <= 1'b0;
      p_lat_q       <= 1'b0;
      p_lon_q       <= 1'b0;
      pend_q        <= '0;
      source_q      <= TALKER_NONE;
      comm_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_START_CHAR: start_char_q <= cfg_data_i;
          CFG_END_MARK:   end_char_q   <= cfg_data_i;
          CFG_SEPARATOR:  sep_char_q   <= cfg_data_i;
          default: ;
        endcase
      end
      in_sentence_q <= in_sentence_d;
      field_num_q   <= field_num_d;
      field_len_q   <= field_len_d;
      char_pos_q    <= char_pos_d;
      talker_q      <= talker_d;
      kind_chars_q  <= kind_chars_d;
      capture_q     <= capture_d;
      end_seen_q    <= end_seen_d;
      sat_acc_q     <= sat_acc_d;
      sat_run_q     <= sat_run_d;
      p_time_q      <= p_time_d;
      p_date_q      <= p_date_d;
      p_sats_q      <= p_sats_d;
      p_lat_q       <= p_lat_d;
      p_lon_q       <= p_lon_d;
      pend_q        <= pend_d;
      source_q      <= source_d;
      comm_q        <= comm_d;
    end
  end

  // result register plus one-entry skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_ready) out_valid_q  <= 1'b1;
      else           skid_valid_q <= 1'b1;
    end else if (out_ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready) out_q <= skid_q;
    end else if (res_valid) begin
      if (out_ready) out_q  <= res;
      else           skid_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sentence_ok_o     = out_q.ok;
  assign message_kind_o    = out_q.kind;
  assign talker_code_o     = out_q.talker;
  assign hour_value_o      = out_q.vals.hour;
  assign minute_value_o    = out_q.vals.minute;
  assign second_value_o    = out_q.vals.second;
  assign day_value_o       = out_q.vals.day;
  assign month_value_o     = out_q.vals.month;
  assign year_value_o      = out_q.vals.year;
  assign satellite_count_o = out_q.vals.sats;
  assign lat_hemisphere_o  = out_q.vals.lat;
  assign lon_hemisphere_o  = out_q.vals.lon;

endmodule

// File: sim/nmea_sentence_field_extractor_tb.sv
// Self-checking testbench for the NMEA sentence field extractor: directed and random byte streams.
module nmea_sentence_field_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsfe_pkg::*;

  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic [1:0] cfg_index_i    = CFG_START_CHAR;
  logic [7:0] cfg_data_i     = 8'h00;
  logic       in_valid_i     = 1'b0;
  logic [7:0] rx_byte_i      = 8'h00;
  logic       out_stall_i    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       sentence_ok_o;
  logic [2:0] message_kind_o;
  logic [2:0] talker_code_o;
  logic [6:0] hour_value_o;
  logic [6:0] minute_value_o;
  logic [6:0] second_value_o;
  logic [6:0] day_value_o;
  logic [6:0] month_value_o;
  logic [6:0] year_value_o;
  logic [6:0] satellite_count_o;
  logic [7:0] lat_hemisphere_o;
  logic [7:0] lon_hemisphere_o;

  nmea_sentence_field_extractor u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sentence_ok_o     (sentence_ok_o),
    .message_kind_o    (message_kind_o),
    .talker_code_o     (talker_code_o),
    .hour_value_o      (hour_value_o),
    .minute_value_o    (minute_value_o),
    .second_value_o    (second_value_o),
    .day_value_o       (day_value_o),
    .month_value_o     (month_value_o),
    .year_value_o      (year_value_o),
    .satellite_count_o (satellite_count_o),
    .lat_hemisphere_o  (lat_hemisphere_o),
    .lon_hemisphere_o  (lon_hemisphere_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  int unsigned send_gap_pct   = 25;
  int unsigned recv_stall_pct = 59;
  int unsigned errors         = 0;
  int unsigned idle_cycles    = 0;
  int unsigned parsed_bytes   = 0;
  int unsigned reports_made   = 0;

  result_t    sentence_reports_q[$];
  logic [7:0] line_q[$];

  string talker_names[5] = '{"GP", "LL", "GL", "GB", "GN"};
  string kind_names[6]   = '{"GGA", "GLL", "GSA", "GSV", "RMC", "VTG"};
  string hex_digits      = "0123456789ABCDEF";
  string compass         = "NSEW";

  // ---------------------------------------------------------------- parser shadow
  logic [7:0]  cfg_start, cfg_end, cfg_sep;
  bit          p_open, p_mark, p_sat_run;
  int unsigned p_field, p_len, p_pos, p_sat;
  logic [7:0]  p_talk[2];
  logic [7:0]  p_type[3];
  logic [7:0]  p_cap[6];
  bit          pend_time, pend_date, pend_sats, pend_lat, pend_lon;
  logic [6:0]  pend_hms[3];
  logic [6:0]  pend_dmy[3];
  logic [6:0]  pend_sats_v;
  logic [7:0]  pend_lat_v, pend_lon_v;
  logic [2:0]  held_talker;
  values_t     held_vals;

  function automatic bit is_num(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic [6:0] two_digits(input logic [7:0] a, input logic [7:0] b);
    int hi, lo;
    hi = a - 8'h30;
    lo = b - 8'h30;
    if (!is_num(a)) return 7'd0;
    if (!is_num(b)) return 7'(hi);
    return 7'(hi * 10 + lo);
  endfunction

  function automatic logic [2:0] kind_of();
    if (p_pos < 5) return KIND_UNKNOWN;
    case ({p_type[0], p_type[1], p_type[2]})
      "GGA":   return KIND_GGA;
      "GLL":   return KIND_GLL;
      "GSA":   return KIND_GSA;
      "GSV":   return KIND_GSV;
      "RMC":   return KIND_RMC;
      "VTG":   return KIND_VTG;
      default: return KIND_UNKNOWN;
    endcase
  endfunction

  function automatic logic [2:0] talker_of();
    case ({p_talk[0], p_talk[1]})
      "GP":    return TALKER_GP;
      "LL":    return TALKER_LL;
      "GL":    return TALKER_GL;
      "GB":    return TALKER_GB;
      "GN":    return TALKER_GN;
      default: return TALKER_NONE;
    endcase
  endfunction

  task automatic open_field();
    p_len = 0;
    foreach (p_cap[i]) p_cap[i] = 8'h00;
    p_sat     = 0;
    p_sat_run = 1'b1;
  endtask

  task automatic open_sentence();
    p_open  = 1'b1;
    p_field = 0;
    p_pos   = 0;
    p_mark  = 1'b0;
    foreach (p_talk[i]) p_talk[i] = 8'h00;
    foreach (p_type[i]) p_type[i] = 8'h00;
    {pend_time, pend_date, pend_sats, pend_lat, pend_lon} = '0;
    open_field();
  endtask

  task automatic close_field();
    if (p_field == FLD_TIME && p_len >= 6) begin
      for (int i = 0; i < 3; i++) pend_hms[i] = two_digits(p_cap[2*i], p_cap[2*i+1]);
      pend_time = 1'b1;
    end else if (p_field == FLD_DATE && p_len >= 6) begin
      for (int i = 0; i < 3; i++) pend_dmy[i] = two_digits(p_cap[2*i], p_cap[2*i+1]);
      pend_date = 1'b1;
    end else if (p_field == FLD_LAT) begin
      pend_lat_v = (p_len != 0) ? p_cap[0] : 8'h00;
      pend_lat   = 1'b1;
    end else if (p_field == FLD_LON) begin
      pend_lon_v = (p_len != 0) ? p_cap[0] : 8'h00;
      pend_lon   = 1'b1;
    end else if (p_field == FLD_SATS) begin
      pend_sats_v = 7'(p_sat);
      pend_sats   = 1'b1;
    end
    if (p_field < MAX_FIELDS) p_field++;
    open_field();
  endtask

  task automatic predictor_reset();
    cfg_start = START_RESET;
    cfg_end   = END_RESET;
    cfg_sep   = SEP_RESET;
    open_sentence();
    p_open = 1'b0;
    foreach (pend_hms[i]) begin
      pend_hms[i] = '0;
      pend_dmy[i] = '0;
    end
    pend_sats_v = '0;
    pend_lat_v  = '0;
    pend_lon_v  = '0;
    held_talker = TALKER_NONE;
    held_vals   = '0;
  endtask

  // Called for every accepted input beat.
  task automatic parse_byte(input logic [7:0] c);
    logic [2:0] kind;
    result_t    r;
    if (!p_open) begin
      if (c == cfg_start) begin
        parsed_bytes++;
        open_sentence();
      end
      return;
    end
    parsed_bytes++;
    if (c != NEWLINE_CHAR) begin
      if (c == cfg_end) p_mark = 1'b1;
      if (p_pos < 2) p_talk[p_pos] = c;
      else if (p_pos < 5) p_type[p_pos-2] = c;
      if (p_pos < 5) p_pos++;
      if (c == cfg_sep) begin
        close_field();
      end else begin
        if (p_len < 6) p_cap[p_len] = c;
        if (p_len < 15) p_len++;
        if (p_sat_run && is_num(c)) begin
          p_sat = p_sat * 10 + (c - 8'h30);
          if (p_sat > 99) p_sat = 99;
        end else begin
          p_sat_run = 1'b0;
        end
      end
      return;
    end
    p_open = 1'b0;
    kind   = kind_of();
    if (p_mark) begin
      if (held_talker == TALKER_NONE && p_pos >= 2) held_talker = talker_of();
      if (kind == KIND_GGA || kind == KIND_RMC) begin
        if (pend_time) begin
          held_vals.hour   = pend_hms[0];
          held_vals.minute = pend_hms[1];
          held_vals.second = pend_hms[2];
        end
      end
      if (kind == KIND_GGA && pend_sats) held_vals.sats = pend_sats_v;
      if (kind == KIND_RMC) begin
        if (pend_date) begin
          held_vals.day   = pend_dmy[0];
          held_vals.month = pend_dmy[1];
          held_vals.year  = pend_dmy[2];
        end
        if (pend_lat) held_vals.lat = pend_lat_v;
        if (pend_lon) held_vals.lon = pend_lon_v;
      end
    end
    r.ok     = p_mark;
    r.kind   = kind;
    r.talker = held_talker;
    r.vals   = held_vals;
    sentence_reports_q.push_back(r);
    reports_made++;
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    parse_byte(b);
  endtask

  task automatic put_byte(input logic [7:0] b);
    line_q.push_back(b);
  endtask

  // '$', '*' and ',' in directed text stand for the current start, end-mark and separator
  task automatic put_mapped(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c == "$") c = cfg_start;
      else if (c == "*") c = cfg_end;
      else if (c == ",") c = cfg_sep;
      line_q.push_back(c);
    end
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic send_text(input string s);
    put_mapped(s);
    send_line();
  endtask

  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sentence_reports_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_registers(input logic [7:0] s, input logic [7:0] e,
                                 input logic [7:0] p);
    logic [7:0] vals[3];
    logic [1:0] idx[3];
    vals = '{s, e, p};
    idx  = '{CFG_START_CHAR, CFG_END_MARK, CFG_SEPARATOR};
    drain_block();
    for (int i = 0; i < 3; i++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    cfg_start = s;
    cfg_end   = e;
    cfg_sep   = p;
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(19) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h7E, 8'h20));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_reg_value();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    while (v == NEWLINE_CHAR) v = 8'($urandom_range(255));
    return v;
  endfunction

  task automatic put_field(input int idx);
    int r;
    r = $urandom_range(9);
    if (idx == FLD_TIME || idx == FLD_DATE) begin
      if (r < 7) begin
        repeat (6) put_byte(rand_digit());
        if ($urandom_range(1)) begin
          put_byte(".");
          put_byte(rand_digit());
          put_byte(rand_digit());
        end
      end else if (r == 7) begin
        repeat ($urandom_range(5)) put_byte(rand_digit());
      end else begin
        repeat ($urandom_range(8, 6)) put_byte($urandom_range(1) ? rand_digit() : rand_char());
      end
    end else if (idx == FLD_LAT || idx == FLD_LON) begin
      if (r < 5) put_byte(compass[$urandom_range(3)]);
      else if (r >= 8) put_byte(rand_char());
    end else if (idx == FLD_SATS) begin
      repeat ($urandom_range(4)) put_byte(rand_digit());
      if (r < 2) put_byte(rand_char());
    end else begin
      repeat ($urandom_range(7)) put_byte(rand_char());
    end
  endtask

  task automatic build_random_sentence();
    int         r, nf;
    logic [7:0] b;
    // a few bytes of line noise while idle
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        b = 8'($urandom_range(255));
        while (b == cfg_start) b = 8'($urandom_range(255));
        put_byte(b);
      end
    end
    put_byte(cfg_start);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(20)) put_byte(8'($urandom_range(255)));
      put_byte(NEWLINE_CHAR);
      return;
    end
    if ($urandom_range(9) < 7) begin
      put_mapped(talker_names[$urandom_range(4)]);
    end else begin
      put_byte(rand_char());
      put_byte(rand_char());
    end
    if ($urandom_range(9) < 8) begin
      put_mapped(kind_names[$urandom_range(5)]);
    end else begin
      repeat (3) put_byte(rand_char());
    end
    r = $urandom_range(99);
    if (r < 10) nf = $urandom_range(3);
    else if (r < 92) nf = $urandom_range(13, 5);
    else nf = $urandom_range(36, 20);
    for (int i = 1; i <= nf; i++) begin
      put_byte(cfg_sep);
      put_field(i);
    end
    if ($urandom_range(1)) put_byte(cfg_sep);
    if ($urandom_range(99) < 85) begin
      put_byte(cfg_end);
      put_byte(hex_digits[$urandom_range(15)]);
      put_byte(hex_digits[$urandom_range(15)]);
    end
    put_byte(NEWLINE_CHAR);
  endtask

  // ---------------------------------------------------------------- receiver and checks
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (sentence_reports_q.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual ok %0d kind %0d",
                 $time, sentence_ok_o, message_kind_o);
        errors++;
      end else begin
        want = sentence_reports_q.pop_front();
        compare_field("sentence_ok", want.ok, sentence_ok_o);
        compare_field("message_kind", want.kind, message_kind_o);
        compare_field("talker_code", want.talker, talker_code_o);
        compare_field("hour_value", want.vals.hour, hour_value_o);
        compare_field("minute_value", want.vals.minute, minute_value_o);
        compare_field("second_value", want.vals.second, second_value_o);
        compare_field("day_value", want.vals.day, day_value_o);
        compare_field("month_value", want.vals.month, month_value_o);
        compare_field("year_value", want.vals.year, year_value_o);
        compare_field("satellite_count", want.vals.sats, satellite_count_o);
        compare_field("lat_hemisphere", want.vals.lat, lat_hemisphere_o);
        compare_field("lon_hemisphere", want.vals.lon, lon_hemisphere_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t timeout: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("nmea_sentence_field_extractor regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_idle_bytes();
    put_mapped("ab*,\n");
    put_byte(8'h00);
    put_byte(8'hFF);
    send_line();
    send_text("$\n");
  endtask

  task automatic test_sentence_kinds();
    send_text("$XXGGA,000000,,,,,,3,*\n");   // accepted, talker unknown stays none
    send_text("$GNGGA,010203,,,,,,12,\n");   // no end mark: nothing committed
    send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\n");
    send_text("$GNRMC,225446,A,4916.45,S,12311.12,W,000.5,054.7,191194,020.3,E*68\n");
    send_text("$GPGLL,4916.45,N,12311.12,W,225444,A,*1D\n");
    send_text("$GPGSA,A,3,04,05,,09,12,,,24,,,,,2.5,1.3,2.1*39\n");
    send_text("$GPGSV,2,1,08,01,40,083,46,02,17,308,41*75\n");
    send_text("$GPVTG,054.7,T,034.4,M,005.5,N,010.2,K*48\n");
  endtask

  task automatic test_value_forms();
    send_text("$GPGGA,1234,,,,,,5,*\n");
    send_text("$GPGGA,1ab2x5,,,,,,12345,*\n");
    send_text("$GPGGA,,,,,,,7x3,*\n");
    send_text("$GPGGA,,,,,,,x,*\n");
    send_text("$GPRMC,235959,A,,,,,,,311299,*\n");
    send_text("$GPGGA,123456*\n");           // time field never closed
  endtask

  task automatic test_odd_sentences();
    send_text("$GP$GA,111111,*\n");
    send_text("$G*\n");
    send_text("$*\n");
    put_mapped("$GPRMC");
    repeat (40) put_byte(cfg_sep);
    put_mapped("*\n");
    send_line();
    put_mapped("$GPGGA,");
    put_byte(8'hFF);
    put_mapped("00000,,,,,,");
    put_byte(8'h00);
    put_mapped(",*\n");
    send_line();
  endtask

  task automatic test_register_extremes();
    write_registers(8'h00, 8'hFF, 8'h80);
    send_text("$GPRMC,101010,A,1,N,2,E,3,x,010203,*\n");
    write_registers(NEWLINE_CHAR, "*", ",");
    send_text("$GPGGA,121212,,,,,,4,*\n");
    // one byte for all three roles
    write_registers("@", "@", "@");
    send_text("$GPGGA,131313,,,,,,6,\n");
    write_registers(8'hFF, 8'h00, 8'h7F);
    send_text("$GPRMC,141414,A,,S,,E,,,020304,*\n");
  endtask

  task automatic test_random_traffic();
    int unsigned base_bytes, base_reports;
    logic [7:0]  s, e, p;
    for (int round = 0; round < 6; round++) begin
      case (round)
        0:       {s, e, p} = {START_RESET, END_RESET, SEP_RESET};
        1:       {s, e, p} = {8'h21, 8'h23, 8'h3B};
        2:       {s, e, p} = {8'h00, 8'hFF, 8'h80};
        3:       {s, e, p} = {rand_reg_value(), rand_reg_value(), rand_reg_value()};
        4:       {s, e, p} = {START_RESET, SEP_RESET, SEP_RESET};
        default: {s, e, p} = {8'hFF, 8'h00, rand_reg_value()};
      endcase
      write_registers(s, e, p);
      if (round < 2) begin
        send_gap_pct   = 25;
        recv_stall_pct = 59;
      end else if (round < 4) begin
        send_gap_pct   = 59;
        recv_stall_pct = 25;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      base_bytes   = parsed_bytes;
      base_reports = reports_made;
      while (parsed_bytes - base_bytes < 24 || reports_made - base_reports < 1) begin
        build_random_sentence();
        send_line();
      end
    end
  endtask

  initial begin
    predictor_reset();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_idle_bytes();
    test_sentence_kinds();
    test_value_forms();
    test_odd_sentences();
    test_register_extremes();
    test_random_traffic();
    drain_block();
    repeat (8) @(posedge clk_i);
    if (sentence_reports_q.size() != 0) begin
      $display("%0t %0d expected result(s) never arrived", $time, sentence_reports_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("nmea_sentence_field_extractor regression: pass");
    end else begin
      $display("nmea_sentence_field_extractor regression: fail");
    end
    $finish;
  end

endmodule
